[hdl/hfsp_pkg.sv]
package hfsp_pkg;

    // Default table size and the width of one occupancy word
    localparam int SLOT_COUNT_DEF = 256;
    localparam int WORD_W         = 32;
    localparam int BIT_W          = 5;

    // Reset value of the max_value register
    localparam logic [7:0] MAX_VALUE_RST = 8'd255;

    typedef logic [2:0] status_t;

    localparam status_t ST_PLACED     = 3'd0;
    localparam status_t ST_DROPPED    = 3'd1;
    localparam status_t ST_REJECTED   = 3'd2;
    localparam status_t ST_READ_FULL  = 3'd3;
    localparam status_t ST_READ_EMPTY = 3'd4;

    // Position of the highest set bit of an occupancy-sized word
    function automatic logic [BIT_W-1:0] hi_pos(input logic [WORD_W-1:0] x);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (x[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

[hdl/hfsp_ifs.sv]
interface hfsp_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] request_value;

    modport source (output valid, output func, output request_value, input ready);
    modport sink   (input valid, input func, input request_value, output ready);
endinterface

interface hfsp_rsp_if;
    logic                 valid;
    logic                 ready;
    hfsp_pkg::status_t    status;
    logic [7:0]           slot_index;
    logic [7:0]           slot_content;

    modport source (output valid, output status, output slot_index, output slot_content,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input slot_content,
                    output ready);
endinterface

[hdl/highest_free_slot_placer.sv]
// highest_free_slot_placer
//
// Requests come in on req (valid/ready): func 0 places request_value into its
// own slot or, if that is taken, into the highest free slot below it; func 1
// reads one slot. One result per request leaves on rsp (valid/ready).
// cfg_we/cfg_data write max_value, the largest value a place may carry.
//
// A read passes through S_RD and S_FIN. A place scans 32-bit occupancy
// words in S_SCAN, downward from the word holding the request value, and
// then passes to S_FIN. One occupancy word is read from the occupancy
// memory per cycle and checked by a single masked priority encoder.
// A rejected place goes straight to S_FIN. One request is in work at a
// time; req.ready is high only while the block is idle.
//
// Reset: max_value returns to 255 and a clearing pass zeroes the occupancy
// memory, one word per cycle; req.ready stays low meanwhile. A new request
// may transfer while a result still waits on rsp; a further result holds
// in the block until rsp.ready frees the output register.
module highest_free_slot_placer #(
    parameter int SLOT_COUNT = hfsp_pkg::SLOT_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_data,
    hfsp_req_if.sink     req,
    hfsp_rsp_if.source   rsp
);

    localparam int WORD_W = hfsp_pkg::WORD_W;
    localparam int BIT_W  = hfsp_pkg::BIT_W;
    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int WORDS  = (SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // Memories
    logic [WORD_W-1:0] occ_mem [WORDS];
    logic [7:0]        store_mem [SLOT_COUNT];

    // Control and payload registers
    logic [2:0]            state_reg, state_next;
    logic [WA_W-1:0]       clr_reg, clr_next;
    logic [WA_W-1:0]       cur_reg, cur_next;
    logic                  first_reg, first_next;
    logic [BIT_W-1:0]      bit_reg, bit_next;
    logic [7:0]            val_reg, val_next;
    logic                  inrange_reg, inrange_next;
    logic [7:0]            max_reg;
    hfsp_pkg::status_t     pst_reg, pst_next;
    logic [7:0]            pidx_reg, pidx_next;
    logic [7:0]            pcont_reg, pcont_next;
    logic                  ovalid_reg, ovalid_next;
    hfsp_pkg::status_t     ost_reg;
    logic [7:0]            oidx_reg;
    logic [7:0]            ocont_reg;

    // Memory ports
    logic [WORD_W-1:0] occ_q;
    logic [7:0]        store_q;
    logic [WA_W-1:0]   occ_raddr;
    logic              occ_we;
    logic [WA_W-1:0]   occ_waddr;
    logic [WORD_W-1:0] occ_wdata;
    logic [IDX_W-1:0]  store_raddr;
    logic              store_we;
    logic [IDX_W-1:0]  store_waddr;

    // Request decode
    logic [IDX_W-1:0]  in_idx;
    logic [WA_W-1:0]   in_word;
    logic [BIT_W-1:0]  in_bit;
    logic              in_range;
    logic              take;
    logic              out_free;

    // Scan datapath
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] free_bits;
    logic [BIT_W-1:0]  pos;
    logic [WA_W+BIT_W-1:0] found_slot;

    assign in_idx   = IDX_W'(req.request_value);
    assign in_word  = WA_W'(in_idx >> BIT_W);
    assign in_bit   = BIT_W'(in_idx);
    assign in_range = 32'(req.request_value) < SLOT_COUNT;

    assign req.ready = (state_reg == S_IDLE);
    assign take      = req.valid && req.ready;
    assign out_free  = !ovalid_reg || rsp.ready;

    assign mask       = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - bit_reg);
    assign free_bits  = ~occ_q & (first_reg ? mask : {WORD_W{1'b1}});
    assign pos        = hfsp_pkg::hi_pos(free_bits);
    assign found_slot = {cur_reg, pos};

    assign rsp.valid        = ovalid_reg;
    assign rsp.status       = ost_reg;
    assign rsp.slot_index   = oidx_reg;
    assign rsp.slot_content = ocont_reg;

    // Pick read addresses: the request's word on transfer, the next lower word in a scan
    always_comb
    begin
        occ_raddr   = (state_reg == S_SCAN) ? (cur_reg - WA_W'(1)) : in_word;
        store_raddr = in_idx;
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        first_next   = first_reg;
        bit_next     = bit_reg;
        val_next     = val_reg;
        inrange_next = inrange_reg;
        pst_next     = pst_reg;
        pidx_next    = pidx_reg;
        pcont_next   = pcont_reg;
        ovalid_next  = ovalid_reg && !rsp.ready;
        occ_we       = 1'b0;
        occ_waddr    = cur_reg;
        occ_wdata    = occ_q | (WORD_W'(1) << pos);
        store_we     = 1'b0;
        store_waddr  = IDX_W'(found_slot);

        unique case (state_reg)
            S_CLR:
            begin
                // Zero one occupancy word per cycle
                occ_we    = 1'b1;
                occ_waddr = clr_reg;
                occ_wdata = '0;
                clr_next  = clr_reg + WA_W'(1);
                if (clr_reg == WA_W'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    cur_next     = in_word;
                    first_next   = 1'b1;
                    bit_next     = in_bit;
                    val_next     = req.request_value;
                    inrange_next = in_range;
                    if (req.func)
                    begin
                        state_next = S_RD;
                    end
                    else if (!in_range || req.request_value > max_reg)
                    begin
                        pst_next   = hfsp_pkg::ST_REJECTED;
                        pidx_next  = '0;
                        pcont_next = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_RD:
            begin
                // Report the slot's content if occupied
                pidx_next = val_reg;
                if (inrange_reg && occ_q[bit_reg])
                begin
                    pst_next   = hfsp_pkg::ST_READ_FULL;
                    pcont_next = store_q;
                end
                else
                begin
                    pst_next   = hfsp_pkg::ST_READ_EMPTY;
                    pcont_next = '0;
                end
                state_next = S_FIN;
            end
            S_SCAN:
            begin
                priority if (|free_bits)
                begin
                    // Claim the highest free slot in this word
                    occ_we     = 1'b1;
                    store_we   = 1'b1;
                    pst_next   = hfsp_pkg::ST_PLACED;
                    pidx_next  = 8'(found_slot);
                    pcont_next = val_reg;
                    state_next = S_FIN;
                end
                else if (cur_reg == '0)
                begin
                    pst_next   = hfsp_pkg::ST_DROPPED;
                    pidx_next  = '0;
                    pcont_next = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    // Advance to the next lower word
                    cur_next   = cur_reg - WA_W'(1);
                    first_next = 1'b0;
                end
            end
            S_FIN:
            begin
                // Hold the result until the output register is free
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            max_reg    <= hfsp_pkg::MAX_VALUE_RST;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        first_reg   <= first_next;
        bit_reg     <= bit_next;
        val_reg     <= val_next;
        inrange_reg <= inrange_next;
        pst_reg     <= pst_next;
        pidx_reg    <= pidx_next;
        pcont_reg   <= pcont_next;
        if (state_reg == S_FIN && out_free)
        begin
            ost_reg   <= pst_reg;
            oidx_reg  <= pidx_reg;
            ocont_reg <= pcont_reg;
        end
    end

    // Occupancy memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        occ_q <= occ_mem[occ_raddr];
    end

    // Slot content memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= val_reg;
        end
        store_q <= store_mem[store_raddr];
    end

endmodule

[bench/tb_highest_free_slot_placer.sv]
`timescale 1ns / 1ps

module tb_highest_free_slot_placer;

    localparam int SLOTS       = hfsp_pkg::SLOT_COUNT_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 20;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] value;
    } slot_req_t;

    typedef struct packed {
        hfsp_pkg::status_t status;
        logic [7:0]        slot_index;
        logic [7:0]        slot_content;
    } slot_outcome_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;

    hfsp_req_if req_ch ();
    hfsp_rsp_if rsp_ch ();

    highest_free_slot_placer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    // Shadow copy of the slot table and the limit register
    bit         occupied [SLOTS];
    logic [7:0] held_value [SLOTS];
    logic [7:0] max_limit = hfsp_pkg::MAX_VALUE_RST;

    slot_req_t     queued_requests [$];
    slot_outcome_t expected_outcomes [$];

    int n_sent      = 0;
    int n_taken     = 0;
    int n_bad       = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    int hold_asks   = 0;
    int hold_served = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
        begin
            return 0;
        end
        if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Apply one request to the shadow table and return the outcome it causes
    function automatic slot_outcome_t slot_outcome(slot_req_t r);
        int s;
        if (r.func == OP_READ)
        begin
            if (int'(r.value) < SLOTS && occupied[r.value])
            begin
                return '{hfsp_pkg::ST_READ_FULL, r.value, held_value[r.value]};
            end
            return '{hfsp_pkg::ST_READ_EMPTY, r.value, 8'd0};
        end
        if (r.value > max_limit || int'(r.value) >= SLOTS)
        begin
            return '{hfsp_pkg::ST_REJECTED, 8'd0, 8'd0};
        end
        // Walk down from the preferred slot to the first free one
        for (s = int'(r.value); s >= 0; s--)
        begin
            if (!occupied[s])
            begin
                occupied[s]   = 1'b1;
                held_value[s] = r.value;
                return '{hfsp_pkg::ST_PLACED, 8'(s), r.value};
            end
        end
        return '{hfsp_pkg::ST_DROPPED, 8'd0, 8'd0};
    endfunction

    // Request driver: present queued items, idle between them at random
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (n_sent != n_taken)
        begin
            // hold the offered item until its transfer
        end
        else if (gap_left > 0)
        begin
            req_ch.valid <= 1'b0;
            gap_left     <= gap_left - 1;
        end
        else if (queued_requests.size() != 0)
        begin
            slot_req_t r;
            r = queued_requests.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.func          <= r.func;
            req_ch.request_value <= r.value;
            n_sent               <= n_sent + 1;
            gap_left             <= pick_gap();
        end
        else
        begin
            req_ch.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus a long hold-off when asked
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_asks != hold_served)
        begin
            rsp_ch.ready <= 1'b0;
            hold_served  <= hold_served + 1;
            hold_left    <= HOLD_CYCLES;
        end
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                stall_left <= pick_gap();
            end
        end
    end

    // Track register writes, predict on request transfer, check each result
    always @(posedge clk)
    begin
        slot_outcome_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                max_limit = cfg_data;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                expected_outcomes.push_back(
                    slot_outcome('{req_ch.func, req_ch.request_value}));
                n_taken <= n_taken + 1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result with nothing expected: status %0d index %0d content %0d",
                           rsp_ch.status, rsp_ch.slot_index, rsp_ch.slot_content);
                    n_bad++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        n_bad++;
                    end
                    if (rsp_ch.slot_index !== want.slot_index)
                    begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, rsp_ch.slot_index);
                        n_bad++;
                    end
                    if (rsp_ch.slot_content !== want.slot_content)
                    begin
                        $error("slot_content: expected %0d, got %0d",
                               want.slot_content, rsp_ch.slot_content);
                        n_bad++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_req(input logic func, input logic [7:0] value);
        queued_requests.push_back('{func, value});
    endtask

    // Block until every queued item has transferred and every result is back
    task automatic wait_idle();
        while (queued_requests.size() != 0 || n_sent != n_taken
               || expected_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_max(input logic [7:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Mixed reads and places; places come singly or in bursts of one value
    task automatic queue_random(input int count, input int read_pct, input int val_hi);
        slot_req_t r;
        int        made;
        int        burst;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 99) < read_pct)
            begin
                r.func  = OP_READ;
                r.value = 8'($urandom_range(0, 255));
                queued_requests.push_back(r);
                made++;
            end
            else
            begin
                r.func = OP_PLACE;
                if ($urandom_range(0, 7) == 0)
                begin
                    r.value = 8'($urandom_range(0, 255));
                end
                else
                begin
                    r.value = 8'($urandom_range(0, val_hi));
                end
                burst = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 24) : 1;
                repeat (burst)
                begin
                    queued_requests.push_back(r);
                    made++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_data             = 8'd0;
        req_ch.valid         = 1'b0;
        req_ch.func          = OP_PLACE;
        req_ch.request_value = 8'd0;
        rsp_ch.ready         = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty reads, collisions, the bottom slot, the top slot
        write_max(8'd255);
        push_req(OP_READ, 8'd0);
        push_req(OP_READ, 8'd255);
        push_req(OP_PLACE, 8'd0);
        push_req(OP_PLACE, 8'd0);
        push_req(OP_PLACE, 8'd255);
        push_req(OP_PLACE, 8'd255);
        push_req(OP_READ, 8'd255);
        push_req(OP_READ, 8'd254);
        push_req(OP_READ, 8'd0);
        push_req(OP_PLACE, 8'd128);
        push_req(OP_PLACE, 8'd128);
        push_req(OP_PLACE, 8'd1);
        push_req(OP_READ, 8'd127);
        push_req(OP_READ, 8'd170);

        // Directed at the lowest limit: rejects, a drop, a read above the limit
        write_max(8'd0);
        push_req(OP_PLACE, 8'd1);
        push_req(OP_PLACE, 8'd255);
        push_req(OP_PLACE, 8'd0);
        push_req(OP_READ, 8'd255);
        push_req(OP_READ, 8'd128);

        // Random phases across several limits
        write_max(8'd255);
        calm = 1'b1;
        queue_random(150, 15, 255);
        wait_idle();
        calm = 1'b0;

        write_max(8'd63);
        queue_random(100, 25, 80);

        // Long receiver hold-off while requests keep coming
        write_max(8'd200);
        hold_asks = hold_asks + 1;
        queue_random(100, 20, 220);

        write_max(8'd0);
        queue_random(50, 30, 10);

        write_max(8'd255);
        queue_random(200, 40, 255);

        wait_idle();
        repeat (DRAIN) @(posedge clk);
        if (n_bad == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/hfsp_pkg.sv
hdl/hfsp_ifs.sv
hdl/highest_free_slot_placer.sv
bench/tb_highest_free_slot_placer.sv
